### design/ccg_pkg.sv
// ----------------------------------------------------------------------------
// ccg_pkg: shared types and codes
// Command and status codes used by the back end and by the testbench.
// ----------------------------------------------------------------------------
`default_nettype none
package ccg_pkg;

    localparam int CMD_W  = 3;
    localparam int STAT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_COLUMN = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_READ   = 3'd3,
        CMD_CHOSEN = 3'd4,
        CMD_MAX    = 3'd5,
        CMD_NOP6   = 3'd6,
        CMD_NOP7   = 3'd7
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_SELF  = 3'd1,
        ST_UNDER = 3'd2,
        ST_SAT   = 3'd3,
        ST_NONE  = 3'd4
    } status_t;

endpackage
`default_nettype wire

### design/ccg_front.sv
// ----------------------------------------------------------------------------
// ccg_front: input stage and command queue
// Registers input beats into a small FIFO so the back end stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none
module ccg_front #(
    parameter int W     = 24,
    parameter int DEPTH = 2
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_data;
        end
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

### design/ccg_back.sv
// ----------------------------------------------------------------------------
// ccg_back: command execution engine
// Sequencer over the edge-count memory: clear sweep, group close, single
// edge updates, reads and the max scan. One result beat per command.
// ----------------------------------------------------------------------------
`default_nettype none
module ccg_back #(
    parameter int VERTICES   = 64,
    parameter int MAX_GROUP  = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [5:0]  group_size,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [5:0]  column,
    input  wire logic        stream_end,
    input  wire logic [5:0]  first_vertex,
    input  wire logic [5:0]  second_vertex,
    input  wire logic        chosen_value,
    input  wire logic        new_line,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [2:0]       res_status,
    output logic [15:0]      res_weight,
    output logic [5:0]       res_first,
    output logic [5:0]       res_second
);
    localparam int VB = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int AB = 2 * VB;
    localparam int GB = $clog2(MAX_GROUP + 1);
    localparam int MB = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CB = COUNT_BITS;
    localparam logic [CB-1:0] CMAX = '1;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_PRD_A = 11'b00000000100,
        S_PRD_B = 11'b00000001000,
        S_PWR   = 11'b00000010000,
        S_GPAIR = 11'b00000100000,
        S_GRD_B = 11'b00001000000,
        S_GWR   = 11'b00010000000,
        S_GFLG  = 11'b00100000000,
        S_SCAN  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg;

    // edge count memory, one write and one registered read per cycle
    logic [CB-1:0] mem [VERTICES*VERTICES];
    logic [AB-1:0] raddr;
    logic [CB-1:0] rdata_reg;
    logic          we;
    logic [AB-1:0] waddr;
    logic [CB-1:0] wdata;

    logic [VB-1:0] members_mem [MAX_GROUP];
    logic [VERTICES-1:0] in_group_reg, chosen_reg;
    logic [GB-1:0] mcount_reg;
    logic [6:0]    items_reg;

    logic [AB:0]   ptr_reg;
    logic [GB-1:0] gi_reg, gj_reg;
    logic [VB-1:0] x_reg, y_reg;
    logic [CB-1:0] ca_reg;
    logic [2:0]    cmd_reg;
    logic          all_reg, sat_reg;
    logic [AB-1:0] scan_addr_reg;
    logic          scan_vld_reg;
    logic [CB-1:0] best_reg;
    logic [AB-1:0] best_addr_reg;

    logic [2:0]  st_reg;
    logic [15:0] w_reg;
    logic [5:0]  mf_reg, ms_reg;

    // ab write happens in the cycle after the ba write, using the held ca
    logic          we2_reg;
    logic [AB-1:0] w2a_reg;
    logic [CB-1:0] w2d_reg;

    logic [6:0] gsz;
    logic       xok, yok, colok;
    logic [AB-1:0] ab, ba;

    always_comb begin
        gsz = {1'b0, group_size};
        if (gsz == 7'd0) gsz = 7'd1;
        if (gsz > 7'(MAX_GROUP)) gsz = 7'(MAX_GROUP);
    end

    assign xok   = {26'd0, first_vertex} < 32'(VERTICES);
    assign yok   = {26'd0, second_vertex} < 32'(VERTICES);
    assign colok = {26'd0, column} < 32'(VERTICES);
    assign ab    = {x_reg, y_reg};
    assign ba    = {y_reg, x_reg};

    assign cmd_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_OUT);
    assign res_status = st_reg;
    assign res_weight = w_reg;
    assign res_first  = mf_reg;
    assign res_second = ms_reg;

    always_comb begin
        raddr = ab;
        we    = 1'b0;
        waddr = ab;
        wdata = '0;
        unique case (state_reg)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = ptr_reg[AB-1:0];
            end
            S_PRD_A: raddr = ab;
            S_PRD_B: raddr = ba;
            S_PWR: begin
                raddr = ab;
                if (cmd_reg == ccg_pkg::CMD_ADD && x_reg != y_reg &&
                    ca_reg != CMAX && rdata_reg != CMAX) begin
                    we    = 1'b1;
                    waddr = ba;
                    wdata = rdata_reg + 1'b1;
                end else if (cmd_reg == ccg_pkg::CMD_REMOVE && x_reg != y_reg &&
                             ca_reg != '0 && rdata_reg != '0) begin
                    we    = 1'b1;
                    waddr = ba;
                    wdata = rdata_reg - 1'b1;
                end
            end
            S_GPAIR: raddr = ab;
            S_GRD_B: raddr = ba;
            S_GWR: begin
                raddr = ab;
                if (ca_reg != CMAX && rdata_reg != CMAX) begin
                    we    = 1'b1;
                    waddr = ba;
                    wdata = rdata_reg + 1'b1;
                end
            end
            S_SCAN: raddr = scan_addr_reg;
            default: raddr = ab;
        endcase
        // deferred write lands in S_OUT or S_GFLG, where nothing else writes
        if (we2_reg) begin
            we    = 1'b1;
            waddr = w2a_reg;
            wdata = w2d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && cmd_valid && cmd == ccg_pkg::CMD_COLUMN && colok &&
            !in_group_reg[column[VB-1:0]] && mcount_reg < GB'(MAX_GROUP)) begin
            members_mem[mcount_reg[MB-1:0]] <= column[VB-1:0];
        end
    end

    logic [MB-1:0] mi, mj;
    assign mi = gi_reg[MB-1:0];
    assign mj = gj_reg[MB-1:0];

    logic [AB-1:0] cmp_addr_reg;
    logic [VB-1:0] best_sel_row, best_sel_col;
    assign best_sel_row = cmp_addr_reg[AB-1:VB];
    assign best_sel_col = cmp_addr_reg[VB-1:0];

    always_ff @(posedge aclk) begin
        cmp_addr_reg <= scan_addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            ptr_reg      <= '0;
            in_group_reg <= '0;
            chosen_reg   <= '0;
            mcount_reg   <= '0;
            items_reg    <= '0;
            we2_reg      <= 1'b0;
        end else begin
            we2_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR: begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg[AB-1:0] == '1) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (cmd_valid) begin
                        cmd_reg <= cmd;
                        all_reg <= new_line;
                        x_reg   <= first_vertex[VB-1:0];
                        y_reg   <= second_vertex[VB-1:0];
                        st_reg  <= ccg_pkg::ST_OK;
                        w_reg   <= '0;
                        mf_reg  <= '0;
                        ms_reg  <= '0;
                        unique case (cmd)
                            ccg_pkg::CMD_COLUMN: begin
                                if (colok && !in_group_reg[column[VB-1:0]] &&
                                    mcount_reg < GB'(MAX_GROUP)) begin
                                    in_group_reg[column[VB-1:0]] <= 1'b1;
                                    mcount_reg <= mcount_reg + 1'b1;
                                end
                                if (stream_end || items_reg + 7'd1 >= gsz) begin
                                    gi_reg    <= '0;
                                    gj_reg    <= GB'(1);
                                    sat_reg   <= 1'b0;
                                    state_reg <= S_GFLG;
                                    items_reg <= '0;
                                end else begin
                                    items_reg <= items_reg + 7'd1;
                                    state_reg <= S_OUT;
                                end
                            end
                            ccg_pkg::CMD_ADD, ccg_pkg::CMD_REMOVE, ccg_pkg::CMD_READ: begin
                                state_reg <= (xok && yok) ? S_PRD_A : S_OUT;
                            end
                            ccg_pkg::CMD_CHOSEN: begin
                                if (xok) chosen_reg[first_vertex[VB-1:0]] <= chosen_value;
                                state_reg <= S_OUT;
                            end
                            ccg_pkg::CMD_MAX: begin
                                scan_addr_reg <= '0;
                                scan_vld_reg  <= 1'b0;
                                ptr_reg       <= '0;
                                best_reg      <= '0;
                                best_addr_reg <= '0;
                                state_reg     <= S_SCAN;
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_PRD_A: state_reg <= S_PRD_B;
                S_PRD_B: begin
                    ca_reg    <= rdata_reg;
                    state_reg <= S_PWR;
                end
                S_PWR: begin
                    // rdata holds b; ca holds a
                    if (cmd_reg == ccg_pkg::CMD_ADD) begin
                        if (x_reg == y_reg) begin
                            st_reg <= ccg_pkg::ST_SELF;
                            w_reg  <= 16'(ca_reg);
                        end else if (ca_reg == CMAX || rdata_reg == CMAX) begin
                            st_reg <= ccg_pkg::ST_SAT;
                            w_reg  <= 16'(ca_reg);
                        end else begin
                            we2_reg <= 1'b1;
                            w2a_reg <= ab;
                            w2d_reg <= ca_reg + 1'b1;
                            w_reg   <= 16'(ca_reg + 1'b1);
                        end
                    end else if (cmd_reg == ccg_pkg::CMD_REMOVE) begin
                        if (x_reg == y_reg) begin
                            st_reg <= ccg_pkg::ST_SELF;
                            w_reg  <= 16'(ca_reg);
                        end else if (ca_reg == '0 || rdata_reg == '0) begin
                            st_reg <= ccg_pkg::ST_UNDER;
                            w_reg  <= 16'(ca_reg);
                        end else begin
                            we2_reg <= 1'b1;
                            w2a_reg <= ab;
                            w2d_reg <= ca_reg - 1'b1;
                            w_reg   <= 16'(ca_reg - 1'b1);
                        end
                    end else begin
                        w_reg <= 16'(ca_reg);
                    end
                    state_reg <= S_OUT;
                end
                S_GFLG: begin
                    // walk the pair list (i, j)
                    if (gi_reg + GB'(1) >= mcount_reg || mcount_reg == '0) begin
                        if (sat_reg) st_reg <= ccg_pkg::ST_SAT;
                        ptr_reg   <= '0;
                        state_reg <= S_OUT;
                        in_group_reg <= '0;
                        mcount_reg   <= '0;
                    end else begin
                        x_reg     <= members_mem[mi];
                        y_reg     <= members_mem[mj];
                        state_reg <= S_GPAIR;
                    end
                end
                S_GPAIR: state_reg <= S_GRD_B;
                S_GRD_B: begin
                    ca_reg    <= rdata_reg;
                    state_reg <= S_GWR;
                end
                S_GWR: begin
                    if (ca_reg == CMAX || rdata_reg == CMAX) begin
                        sat_reg <= 1'b1;
                    end else begin
                        we2_reg <= 1'b1;
                        w2a_reg <= ab;
                        w2d_reg <= ca_reg + 1'b1;
                    end
                    if (gj_reg + GB'(1) >= mcount_reg) begin
                        gi_reg <= gi_reg + GB'(1);
                        gj_reg <= gi_reg + GB'(2);
                    end else begin
                        gj_reg <= gj_reg + GB'(1);
                    end
                    state_reg <= S_GFLG;
                end
                S_SCAN: begin
                    // address issued this cycle, data compared next cycle
                    scan_vld_reg  <= !ptr_reg[AB];
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                    if (!ptr_reg[AB]) ptr_reg <= ptr_reg + 1'b1;
                    if (scan_vld_reg) begin
                        if ((all_reg || chosen_reg[best_sel_row] || chosen_reg[best_sel_col])
                            && rdata_reg > best_reg) begin
                            best_reg      <= rdata_reg;
                            best_addr_reg <= cmp_addr_reg;
                        end
                    end
                    if (ptr_reg[AB] && !scan_vld_reg) begin
                        w_reg     <= 16'(best_reg);
                        mf_reg    <= 6'(best_addr_reg[AB-1:VB]);
                        ms_reg    <= 6'(best_addr_reg[VB-1:0]);
                        if (best_reg == '0) st_reg <= ccg_pkg::ST_NONE;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (res_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_CLEAR;
            endcase
        end
    end
endmodule
`default_nettype wire

### design/column_cooccurrence_graph_unit.sv
// ----------------------------------------------------------------------------
// column_cooccurrence_graph_unit: column co-occurrence edge-count graph
// Edge commands read both directions of a pair, then write them back in turn;
// a column beat closing a group walks every pair of members; max scans all V*V.
// Throughput: one command in the back end at a time behind a 2-entry queue;
// a new command is taken only after the result beat of the last is accepted.
// Reset: a clearing pass over all VERTICES*VERTICES entries zeroes the count memory.
// ----------------------------------------------------------------------------
`default_nettype none
module column_cooccurrence_graph_unit #(
    parameter int VERTICES   = 64,
    parameter int MAX_GROUP  = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // column, first_vertex, second_vertex, chosen_value, new_line, pad
    input  wire logic [23:0] s_tdata,
    // stream_end
    input  wire logic        s_tlast,
    // cmd
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status, weight, max_first, max_second, pad
    output logic [31:0]      m_tdata
);
    logic [5:0]  gsize_reg;
    logic        qv, qr;
    logic [23:0] qd;
    logic [2:0]  st;
    logic [15:0] w;
    logic [5:0]  mf, ms;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) gsize_reg <= 6'd32;
        else if (cfg_valid) gsize_reg <= cfg_data;
    end

    ccg_front #(.W(24), .DEPTH(2)) u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_data({s_tuser, s_tlast, s_tdata[19:0]}),
        .out_valid(qv), .out_ready(qr), .out_data(qd)
    );

    ccg_back #(.VERTICES(VERTICES), .MAX_GROUP(MAX_GROUP), .COUNT_BITS(COUNT_BITS)) u_back (
        .aclk, .aresetn, .group_size(gsize_reg),
        .cmd_valid(qv), .cmd_ready(qr),
        .cmd(qd[23:21]), .column(qd[5:0]), .stream_end(qd[20]),
        .first_vertex(qd[11:6]), .second_vertex(qd[17:12]),
        .chosen_value(qd[18]), .new_line(qd[19]),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_status(st), .res_weight(w), .res_first(mf), .res_second(ms)
    );

    assign m_tdata = {1'b0, ms, mf, w, st};
endmodule
`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for column_cooccurrence_graph_unit
// Runs a directed table covering the edge commands, the self, underflow and
// no-result statuses and group closing, then random traffic under several
// sender and receiver idling mixes and group sizes. Typed rows are checked
// against their table results, all other result beats against an in-bench
// model of the edge-count matrix, the group gatherer and the chosen flags.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

    typedef struct {
        ccg_pkg::cmd_t cmd;
        bit [5:0]      column;
        bit            stream_end;
        bit [5:0]      first_v;
        bit [5:0]      second_v;
        bit            chosen_val;
        bit            new_line;
    } cmd_beat_t;

    typedef struct {
        ccg_pkg::status_t status;
        bit [15:0]        weight;
        bit [5:0]         max_first;
        bit [5:0]         max_second;
    } graph_result_t;

    typedef struct {
        cmd_beat_t     beat;
        bit            typed;
        graph_result_t want;
    } table_row_t;

    localparam bit [15:0] COUNT_FULL = 16'hFFFF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // column, first_vertex, second_vertex, chosen_value, new_line, pad
    logic [23:0] s_tdata = '0;
    // stream_end
    logic        s_tlast = 1'b0;
    // cmd
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // status, weight, max_first, max_second, pad
    logic [31:0] m_tdata;

    // graph state
    bit [15:0] edge_count [64][64];
    bit        in_group [64];
    bit        chosen [64];
    int        gathered_cols [$];
    int        items_gathered;
    bit [5:0]  group_size_reg = 6'd32;

    graph_result_t expected_results [$];
    table_row_t    directed_rows [$];
    int            errors = 0;
    int            sender_idle_pct = 0;
    int            stall_pct = 0;

    column_cooccurrence_graph_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic ccg_pkg::status_t bump_edge(int x, int y);
        if (x == y) return ccg_pkg::ST_SELF;
        if (edge_count[x][y] == COUNT_FULL || edge_count[y][x] == COUNT_FULL)
            return ccg_pkg::ST_SAT;
        edge_count[x][y]++;
        edge_count[y][x]++;
        return ccg_pkg::ST_OK;
    endfunction

    function automatic graph_result_t apply_command(cmd_beat_t b);
        graph_result_t r;
        int            eff;
        int            x;
        int            y;
        bit [15:0]     best;
        r = '{ccg_pkg::ST_OK, 16'd0, 6'd0, 6'd0};
        x = b.first_v;
        y = b.second_v;
        case (b.cmd)
            ccg_pkg::CMD_COLUMN: begin
                if (!in_group[b.column] && gathered_cols.size() < 32) begin
                    in_group[b.column] = 1'b1;
                    gathered_cols.push_back(b.column);
                end
                items_gathered++;
                eff = (group_size_reg == 0) ? 1 : (group_size_reg > 32) ? 32 : group_size_reg;
                if (b.stream_end || items_gathered >= eff) begin
                    foreach (gathered_cols[i])
                        for (int j = i + 1; j < gathered_cols.size(); j++)
                            if (bump_edge(gathered_cols[i], gathered_cols[j]) != ccg_pkg::ST_OK)
                                r.status = ccg_pkg::ST_SAT;
                    foreach (gathered_cols[i]) in_group[gathered_cols[i]] = 1'b0;
                    gathered_cols.delete();
                    items_gathered = 0;
                end
            end
            ccg_pkg::CMD_ADD: begin
                r.status = bump_edge(x, y);
                r.weight = edge_count[x][y];
            end
            ccg_pkg::CMD_REMOVE: begin
                if (x == y) r.status = ccg_pkg::ST_SELF;
                else if (edge_count[x][y] == 0 || edge_count[y][x] == 0)
                    r.status = ccg_pkg::ST_UNDER;
                else begin
                    edge_count[x][y]--;
                    edge_count[y][x]--;
                end
                r.weight = edge_count[x][y];
            end
            ccg_pkg::CMD_READ: r.weight = edge_count[x][y];
            ccg_pkg::CMD_CHOSEN: chosen[x] = b.chosen_val;
            ccg_pkg::CMD_MAX: begin
                best = 0;
                for (int i = 0; i < 64; i++)
                    for (int j = 0; j < 64; j++)
                        if ((b.new_line || chosen[i] || chosen[j]) && edge_count[i][j] > best) begin
                            best = edge_count[i][j];
                            r.max_first = 6'(i);
                            r.max_second = 6'(j);
                        end
                if (best == 0) r.status = ccg_pkg::ST_NONE;
                r.weight = best;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        graph_result_t w;
        if (m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report("unexpected result beat", m_tdata, 0);
            end else begin
                w = expected_results.pop_front();
                if (m_tdata[2:0] != w.status) report("status", m_tdata[2:0], w.status);
                if (m_tdata[18:3] != w.weight) report("weight", m_tdata[18:3], w.weight);
                if (m_tdata[24:19] != w.max_first) report("max_first", m_tdata[24:19], w.max_first);
                if (m_tdata[30:25] != w.max_second)
                    report("max_second", m_tdata[30:25], w.max_second);
            end
        end
    end

    task automatic send_beat(cmd_beat_t b, bit typed, graph_result_t want);
        graph_result_t p;
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.cmd;
        s_tlast  <= b.stream_end;
        s_tdata  <= {4'd0, b.new_line, b.chosen_val, b.second_v, b.first_v, b.column};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = apply_command(b);
        expected_results.push_back(typed ? want : p);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_group_size(bit [5:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        group_size_reg = v;
    endtask

    function automatic cmd_beat_t mk(ccg_pkg::cmd_t c, int col, bit se, int fv, int sv,
                                     bit cv, bit nl);
        mk = '{c, col[5:0], se, fv[5:0], sv[5:0], cv, nl};
    endfunction

    function automatic void add_row(cmd_beat_t b, bit typed, ccg_pkg::status_t st, int w,
                                    int mf, int ms);
        table_row_t t;
        t.beat  = b;
        t.typed = typed;
        t.want  = '{st, w[15:0], mf[5:0], ms[5:0]};
        directed_rows.push_back(t);
    endfunction

    function automatic int pick_vertex();
        return int'(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(15));
    endfunction

    function automatic cmd_beat_t random_beat();
        cmd_beat_t b;
        int        r;
        b = mk(ccg_pkg::CMD_COLUMN, int'($urandom_range(63)), 1'($urandom_range(1)),
               int'($urandom_range(63)), int'($urandom_range(63)), 1'($urandom_range(1)),
               1'($urandom_range(1)));
        r = int'($urandom_range(999));
        if (r < 600) begin
            b.column     = 6'(pick_vertex());
            b.stream_end = ($urandom_range(9) == 0);
        end else begin
            b.first_v  = 6'(pick_vertex());
            b.second_v = ($urandom_range(19) == 0) ? b.first_v : 6'(pick_vertex());
            if (r < 700)      b.cmd = ccg_pkg::CMD_ADD;
            else if (r < 780) b.cmd = ccg_pkg::CMD_REMOVE;
            else if (r < 850) b.cmd = ccg_pkg::CMD_READ;
            else if (r < 920) b.cmd = ccg_pkg::CMD_CHOSEN;
            else if (r < 935) b.cmd = ccg_pkg::CMD_MAX;
            else if (r < 943) b.cmd = ccg_pkg::CMD_NOP6;
            else if (r < 950) b.cmd = ccg_pkg::CMD_NOP7;
            else              b.cmd = ccg_pkg::CMD_ADD;
        end
        return b;
    endfunction

    initial begin
        int            idle_mix [4];
        int            stall_mix [4];
        bit [5:0]      sizes [4];
        graph_result_t none;
        none = '{ccg_pkg::ST_OK, 16'd0, 6'd0, 6'd0};
        idle_mix  = '{0, 64, 0, 19};
        stall_mix = '{0, 0, 64, 19};
        sizes     = '{6'd1, 6'd0, 6'd63, 6'd5};

        add_row(mk(ccg_pkg::CMD_MAX, 0, 0, 0, 0, 0, 1), 1, ccg_pkg::ST_NONE, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_READ, 63, 1, 0, 63, 1, 1), 1, ccg_pkg::ST_OK, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_ADD, 0, 0, 5, 5, 0, 0), 1, ccg_pkg::ST_SELF, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_REMOVE, 0, 0, 3, 4, 0, 0), 1, ccg_pkg::ST_UNDER, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_REMOVE, 0, 0, 9, 9, 0, 0), 1, ccg_pkg::ST_SELF, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_ADD, 0, 0, 0, 63, 0, 0), 1, ccg_pkg::ST_OK, 1, 0, 0);
        add_row(mk(ccg_pkg::CMD_READ, 0, 0, 63, 0, 0, 0), 1, ccg_pkg::ST_OK, 1, 0, 0);
        add_row(mk(ccg_pkg::CMD_READ, 0, 0, 7, 7, 0, 0), 1, ccg_pkg::ST_OK, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_REMOVE, 0, 0, 0, 63, 0, 0), 1, ccg_pkg::ST_OK, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_ADD, 0, 0, 62, 1, 0, 0), 1, ccg_pkg::ST_OK, 1, 0, 0);
        add_row(mk(ccg_pkg::CMD_CHOSEN, 0, 0, 62, 0, 1, 0), 1, ccg_pkg::ST_OK, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_MAX, 0, 0, 0, 0, 0, 0), 1, ccg_pkg::ST_OK, 1, 1, 62);
        add_row(mk(ccg_pkg::CMD_CHOSEN, 63, 1, 62, 63, 0, 1), 1, ccg_pkg::ST_OK, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_MAX, 0, 0, 0, 0, 0, 0), 1, ccg_pkg::ST_NONE, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_MAX, 0, 0, 0, 0, 0, 1), 1, ccg_pkg::ST_OK, 1, 1, 62);
        add_row(mk(ccg_pkg::CMD_NOP6, 63, 1, 63, 63, 1, 1), 1, ccg_pkg::ST_OK, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_NOP7, 63, 1, 63, 63, 1, 1), 1, ccg_pkg::ST_OK, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_COLUMN, 63, 0, 63, 63, 1, 1), 1, ccg_pkg::ST_OK, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_COLUMN, 0, 0, 0, 0, 0, 0), 1, ccg_pkg::ST_OK, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_COLUMN, 63, 0, 0, 0, 0, 0), 1, ccg_pkg::ST_OK, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_COLUMN, 10, 1, 0, 0, 0, 0), 1, ccg_pkg::ST_OK, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_READ, 0, 0, 0, 63, 0, 0), 0, ccg_pkg::ST_OK, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_READ, 0, 0, 10, 63, 0, 0), 0, ccg_pkg::ST_OK, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_CHOSEN, 0, 0, 10, 0, 1, 0), 0, ccg_pkg::ST_OK, 0, 0, 0);
        add_row(mk(ccg_pkg::CMD_MAX, 0, 0, 0, 0, 0, 0), 0, ccg_pkg::ST_OK, 0, 0, 0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        write_group_size(6'd32);
        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

        for (int ph = 0; ph < 4; ph++) begin
            write_group_size(sizes[ph]);
            sender_idle_pct = idle_mix[ph];
            stall_pct       = stall_mix[ph];
            for (int n = 0; n < 270; n++) begin
                if (n == 135 && ph == 1) drain();
                if (n == 135 && ph == 2) write_group_size(6'($urandom_range(2, 31)));
                send_beat(random_beat(), 0, none);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("column_cooccurrence_graph_unit verification clean");
        end else begin
            $display("column_cooccurrence_graph_unit verification failed");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("column_cooccurrence_graph_unit verification failed");
        $finish;
    end

endmodule
`default_nettype wire
